// ----- sv/mlfq_pkg.sv -----
// shared types and codes for the multilevel feedback queue scheduler
package mlfq_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned TASK_W   = 6;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned KIND_W   = 3;

  localparam logic [AGE_W-1:0] MAX_AGE_RST = 16'd30;

  localparam logic [OP_W-1:0] OP_ADMIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_WAKE   = 3'd1;
  localparam logic [OP_W-1:0] OP_SCHED  = 3'd2;
  localparam logic [OP_W-1:0] OP_SLICE  = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADMIT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WAKE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SCHED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SLICE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOP    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD    = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] now;
    logic              demote;
  } mlfq_in_t;

  typedef struct packed {
    logic                granted;
    logic [TASK_W-1:0]   granted_task;
    logic [LEVEL_W-1:0]  granted_level;
    logic [STATUS_W-1:0] status;
  } mlfq_out_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] now;
    logic              demote;
  } mlfq_item_t;

endpackage

// ----- sv/mlfq_front.sv -----
// front end: accepts transactions, classifies them and queues them for the engine
module mlfq_front import mlfq_pkg::*; #(
  parameter int unsigned MAX_TASKS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hold_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mlfq_in_t   in_data_i,
  output logic       deq_valid_o,
  input  logic       deq_ready_i,
  output mlfq_item_t deq_data_o
);

  mlfq_item_t buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  mlfq_item_t cls;
  logic       push, pop;

  always_comb begin
    cls.task_id = in_data_i.task_id;
    cls.now     = in_data_i.now;
    cls.demote  = in_data_i.demote;
    if (in_data_i.operation == OP_SCHED) begin
      cls.kind = KIND_SCHED;
    end else if (in_data_i.operation > OP_REMOVE) begin
      cls.kind = KIND_NOP;
    end else if (32'(in_data_i.task_id) >= MAX_TASKS) begin
      cls.kind = KIND_BAD;
    end else begin
      case (in_data_i.operation)
        OP_ADMIT: cls.kind = KIND_ADMIT;
        OP_WAKE:  cls.kind = KIND_WAKE;
        OP_SLICE: cls.kind = KIND_SLICE;
        default:  cls.kind = KIND_REMOVE;
      endcase
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2) && !hold_i;
  assign deq_valid_o = (cnt_q != 2'd0);
  assign deq_data_o  = buf_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = deq_valid_o && deq_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wptr_q] <= cls;
  end

endmodule

// ----- sv/mlfq_back.sv -----
// back end: sequencer over the level slot memory and per-task tables
module mlfq_back import mlfq_pkg::*; #(
  parameter int unsigned MAX_TASKS  = 64,
  parameter int unsigned NUM_LEVELS = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AGE_W-1:0] max_age_i,
  output logic             clearing_o,
  input  logic             deq_valid_i,
  output logic             deq_ready_o,
  input  mlfq_item_t       deq_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mlfq_out_t        out_data_o
);

  localparam int unsigned TW  = $clog2(MAX_TASKS);
  localparam int unsigned CW  = $clog2(MAX_TASKS + 1);
  localparam int unsigned LW  = $clog2(NUM_LEVELS);
  localparam int unsigned LCW = $clog2(NUM_LEVELS + 1);
  localparam int unsigned SD  = NUM_LEVELS * MAX_TASKS;
  localparam int unsigned SAW = $clog2(SD);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_TLW    = 4'd3;
  localparam logic [3:0] S_PUSH   = 4'd4;
  localparam logic [3:0] S_RMCHK  = 4'd5;
  localparam logic [3:0] S_RMCMP  = 4'd6;
  localparam logic [3:0] S_DEL    = 4'd7;
  localparam logic [3:0] S_DELWR  = 4'd8;
  localparam logic [3:0] S_AGECHK = 4'd9;
  localparam logic [3:0] S_AGET   = 4'd10;
  localparam logic [3:0] S_AGECMP = 4'd11;
  localparam logic [3:0] S_POPSEL = 4'd12;
  localparam logic [3:0] S_POPGET = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  localparam logic RET_DONE = 1'b0;
  localparam logic RET_AGE  = 1'b1;

  function automatic logic [SAW-1:0] slot_addr(logic [LW-1:0] lvl, logic [TW-1:0] pos);
    return SAW'(lvl) * SAW'(MAX_TASKS) + SAW'(pos);
  endfunction

  logic [TASK_W-1:0] slot_mem [SD];
  logic [LW-1:0]     tl_mem [MAX_TASKS];
  logic [TIME_W-1:0] te_mem [MAX_TASKS];
  logic [TASK_W-1:0] slot_rdata_q;
  logic [LW-1:0]     tl_rdata_q;
  logic [TIME_W-1:0] te_rdata_q;

  logic              slot_we;
  logic [SAW-1:0]    slot_waddr, slot_raddr;
  logic [TASK_W-1:0] slot_wdata;
  logic              task_we;
  logic [TW-1:0]     task_widx, task_ridx;
  logic [LW-1:0]     task_wlvl;
  logic [TIME_W-1:0] task_wtime;

  logic [CW-1:0] counts_q [NUM_LEVELS];
  logic          cnt_inc, cnt_dec;
  logic [LW-1:0] cnt_inc_lvl, cnt_dec_lvl;

  logic [3:0]     state_q, state_d;
  mlfq_item_t     item_q, item_d;
  logic [LW-1:0]  lvl_q, lvl_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic [CW-1:0]  j_q, j_d;
  logic [LCW-1:0] age_i_q, age_i_d;
  logic           ret_q, ret_d;
  logic [TW-1:0]  clr_q, clr_d;
  mlfq_out_t      res_q, res_d;
  mlfq_out_t      out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic          pop_found;
  logic [LW-1:0] pop_lvl;
  logic [LW-1:0] age_lvl, age_up;
  logic [LW-1:0] tl_lvl;
  logic [TIME_W-1:0] wait_t;

  always_comb begin
    pop_found = 1'b0;
    pop_lvl   = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (counts_q[l] != '0) begin
        pop_found = 1'b1;
        pop_lvl   = LW'(l);
      end
    end
  end

  assign age_lvl = age_i_q[LW-1:0];
  assign age_up  = LW'(age_i_q - 1'b1);
  assign tl_lvl  = (32'(tl_rdata_q) < NUM_LEVELS) ? tl_rdata_q : LW'(NUM_LEVELS - 1);
  assign wait_t  = item_q.now - te_rdata_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    lvl_d       = lvl_q;
    pos_d       = pos_q;
    j_d         = j_q;
    age_i_d     = age_i_q;
    ret_d       = ret_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    slot_we     = 1'b0;
    slot_waddr  = '0;
    slot_wdata  = '0;
    slot_raddr  = '0;
    task_we     = 1'b0;
    task_widx   = '0;
    task_wlvl   = '0;
    task_wtime  = '0;
    task_ridx   = '0;
    cnt_inc     = 1'b0;
    cnt_inc_lvl = '0;
    cnt_dec     = 1'b0;
    cnt_dec_lvl = '0;
    deq_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        task_we   = 1'b1;
        task_widx = clr_q;
        clr_d     = clr_q + 1'b1;
        if (32'(clr_q) == MAX_TASKS - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        deq_ready_o = 1'b1;
        if (deq_valid_i) begin
          item_d  = deq_data_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        res_d     = '0;
        task_ridx = TW'(item_q.task_id);
        pos_d     = '0;
        case (item_q.kind)
          KIND_ADMIT: begin
            lvl_d   = '0;
            state_d = S_PUSH;
          end
          KIND_WAKE, KIND_SLICE, KIND_REMOVE: state_d = S_TLW;
          KIND_SCHED: begin
            age_i_d = LCW'(1);
            j_d     = '0;
            state_d = S_AGECHK;
          end
          KIND_BAD: begin
            res_d.status = ST_NOTFOUND;
            state_d      = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_TLW: begin
        lvl_d = tl_lvl;
        if (item_q.kind == KIND_REMOVE) begin
          state_d = S_RMCHK;
        end else begin
          if (item_q.kind == KIND_SLICE && item_q.demote && 32'(tl_lvl) + 1 < NUM_LEVELS)
            lvl_d = tl_lvl + 1'b1;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (32'(counts_q[lvl_q]) >= MAX_TASKS) begin
          res_d.status = ST_FULL;
        end else begin
          slot_we     = 1'b1;
          slot_waddr  = slot_addr(lvl_q, counts_q[lvl_q][TW-1:0]);
          slot_wdata  = item_q.task_id;
          cnt_inc     = 1'b1;
          cnt_inc_lvl = lvl_q;
          task_we     = 1'b1;
          task_widx   = TW'(item_q.task_id);
          task_wlvl   = lvl_q;
          task_wtime  = item_q.now;
        end
        state_d = S_DONE;
      end
      S_RMCHK: begin
        if (pos_q >= counts_q[lvl_q]) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          slot_raddr = slot_addr(lvl_q, pos_q[TW-1:0]);
          state_d    = S_RMCMP;
        end
      end
      S_RMCMP: begin
        if (slot_rdata_q == item_q.task_id) begin
          ret_d   = RET_DONE;
          state_d = S_DEL;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = S_RMCHK;
        end
      end
      S_DEL: begin
        if ({1'b0, pos_q} + 1'b1 < {1'b0, counts_q[lvl_q]}) begin
          slot_raddr = slot_addr(lvl_q, TW'(pos_q + 1'b1));
          state_d    = S_DELWR;
        end else begin
          cnt_dec     = 1'b1;
          cnt_dec_lvl = lvl_q;
          state_d     = (ret_q == RET_AGE) ? S_AGECHK : S_DONE;
        end
      end
      S_DELWR: begin
        slot_we    = 1'b1;
        slot_waddr = slot_addr(lvl_q, pos_q[TW-1:0]);
        slot_wdata = slot_rdata_q;
        pos_d      = pos_q + 1'b1;
        state_d    = S_DEL;
      end
      S_AGECHK: begin
        if (32'(age_i_q) >= NUM_LEVELS) begin
          state_d = S_POPSEL;
        end else if (j_q >= counts_q[age_lvl]) begin
          age_i_d = age_i_q + 1'b1;
          j_d     = '0;
        end else begin
          slot_raddr = slot_addr(age_lvl, j_q[TW-1:0]);
          state_d    = S_AGET;
        end
      end
      S_AGET: begin
        task_ridx = TW'(slot_rdata_q);
        item_d.task_id = slot_rdata_q;
        state_d   = S_AGECMP;
      end
      S_AGECMP: begin
        if (wait_t > TIME_W'(max_age_i) && 32'(counts_q[age_up]) < MAX_TASKS) begin
          slot_we     = 1'b1;
          slot_waddr  = slot_addr(age_up, counts_q[age_up][TW-1:0]);
          slot_wdata  = item_q.task_id;
          cnt_inc     = 1'b1;
          cnt_inc_lvl = age_up;
          task_we     = 1'b1;
          task_widx   = TW'(item_q.task_id);
          task_wlvl   = age_up;
          task_wtime  = item_q.now;
          lvl_d       = age_lvl;
          pos_d       = j_q;
          ret_d       = RET_AGE;
          state_d     = S_DEL;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_AGECHK;
        end
      end
      S_POPSEL: begin
        if (!pop_found) begin
          res_d.status = ST_EMPTY;
          state_d      = S_DONE;
        end else begin
          lvl_d      = pop_lvl;
          slot_raddr = slot_addr(pop_lvl, '0);
          state_d    = S_POPGET;
        end
      end
      S_POPGET: begin
        res_d.granted       = 1'b1;
        res_d.granted_task  = slot_rdata_q;
        res_d.granted_level = LEVEL_W'(lvl_q);
        res_d.status        = ST_OK;
        pos_d               = '0;
        ret_d               = RET_DONE;
        state_d             = S_DEL;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) counts_q[l] <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cnt_inc) counts_q[cnt_inc_lvl] <= counts_q[cnt_inc_lvl] + 1'b1;
      if (cnt_dec) counts_q[cnt_dec_lvl] <= counts_q[cnt_dec_lvl] - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    lvl_q   <= lvl_d;
    pos_q   <= pos_d;
    j_q     <= j_d;
    age_i_q <= age_i_d;
    ret_q   <= ret_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rdata_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (task_we) begin
      tl_mem[task_widx] <= task_wlvl;
      te_mem[task_widx] <= task_wtime;
    end
    tl_rdata_q <= tl_mem[task_ridx];
    te_rdata_q <= te_mem[task_ridx];
  end

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/multilevel_feedback_queue_scheduler_unit.sv -----
// top level of the multilevel feedback queue scheduler with aging
//
//  channel  direction  payload      handshake
//  in       input      mlfq_in_t    in_valid_i / in_ready_o
//  out      output     mlfq_out_t   out_valid_o / out_ready_i
//  cfg      input      max_age      cfg_valid_i / cfg_ready_o
//
// admit, wake and slice end append the task to a level; remove scans the slots
// of the task's level and shifts the later slots down; schedule checks the queued
// entries on levels 1 and up for aging, shifting slots on each promotion and on
// the pop, all sequenced around the single read port of the slot memory
// after reset the task tables are cleared with input held off
// a two-entry queue and an output register decouple both sides during stalls
module multilevel_feedback_queue_scheduler_unit import mlfq_pkg::*; #(
  parameter int unsigned MAX_TASKS  = 64,
  parameter int unsigned NUM_LEVELS = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mlfq_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mlfq_out_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AGE_W-1:0] cfg_data_i
);

  logic [AGE_W-1:0] max_age_q;
  logic             clearing;
  logic             deq_valid, deq_ready;
  mlfq_item_t       deq_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MAX_AGE_RST;
    end else if (cfg_valid_i) begin
      max_age_q <= cfg_data_i;
    end
  end

  mlfq_front #(
    .MAX_TASKS(MAX_TASKS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hold_i     (clearing),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .deq_valid_o(deq_valid),
    .deq_ready_i(deq_ready),
    .deq_data_o (deq_data)
  );

  mlfq_back #(
    .MAX_TASKS (MAX_TASKS),
    .NUM_LEVELS(NUM_LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_age_i  (max_age_q),
    .clearing_o (clearing),
    .deq_valid_i(deq_valid),
    .deq_ready_o(deq_ready),
    .deq_data_i (deq_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> out_data_o.status == ST_OK)
    else $error("grant with bad status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.granted |->
      out_data_o.granted_task == '0 && out_data_o.granted_level == '0)
    else $error("nonzero task without grant");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> 32'(out_data_o.granted_level) < NUM_LEVELS)
    else $error("granted level out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o)
    else $error("input accepted during table clear");

endmodule
